>>> rtl/core/gbb_pkg.sv
// gbb_pkg: shared constants, types and helper functions for the gray box blur core
// no dependencies; used by gbb_front, gbb_back and the core top by scoped names
`timescale 1ns / 1ps

package gbb_pkg;

  // default line store depth (pixels per row)
  localparam int MAX_WIDTH_DEF = 1024;

  // configuration register layout
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_HEIGHT_W-1:0] MAX_HEIGHT   = 13'd4096;

  // item kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // luma weights, 8 fractional bits
  localparam logic [15:0] GRAY_R = 16'd77;
  localparam logic [15:0] GRAY_G = 16'd150;
  localparam logic [15:0] GRAY_B = 16'd29;

  // divide by nine: (sum * 7282) >> 16 is exact for sums up to 9*255
  localparam logic [13:0] RECIP_9     = 14'd7282;
  localparam int          RECIP_SHIFT = 16;

  localparam int SUM_W      = 12;
  localparam int MID_DEPTH  = 4;
  localparam int OUT_DEPTH  = 8;

  // classification of one item, made in the front and used in the back
  typedef struct packed {
    logic       have;          // item releases an output pixel
    logic       center_right;  // output column sits in the newest window column
    logic       last;          // final output pixel of the image
    logic [2:0] col_ok;        // window column inside the image, bit 0 = oldest
    logic [2:0] row_ok;        // window row inside the image, bit 0 = upper
  } gbb_ctl_t;

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [15:0] acc;
    acc = 16'(r) * GRAY_R + 16'(g) * GRAY_G + 16'(b) * GRAY_B;
    return acc[15:8];
  endfunction

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
    logic [27:0] prod;
    prod = 28'(sum) * 28'(RECIP_9);
    return prod[RECIP_SHIFT +: 8];
  endfunction

endpackage

>>> rtl/core/gbb_fifo.sv
// gbb_fifo: small first-word-fall-through queue in flip-flops
// no dependencies; used between front and back and on the result side
`timescale 1ns / 1ps

module gbb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNTW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/core/gbb_front.sv
// gbb_front: config registers, raster counters, luma conversion and item classification
// depends on gbb_pkg; feeds the mid queue read by gbb_back
`timescale 1ns / 1ps

module gbb_front #(
  parameter int MAX_WIDTH = gbb_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel side
  input  logic                                push,
  output logic                                full,
  input  logic                                action,
  input  logic [7:0]                          red_in,
  input  logic [7:0]                          green_in,
  input  logic [7:0]                          blue_in,
  // config side
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gbb_pkg::CFG_DATA_W-1:0]      cfg_data,
  // mid queue
  output logic                                q_push,
  input  logic                                q_full,
  output logic [$clog2(MAX_WIDTH)-1:0]        q_col,
  output logic [7:0]                          q_gray,
  output gbb_pkg::gbb_ctl_t                   q_ctl
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > gbb_pkg::CFG_WIDTH_W) ? WW : gbb_pkg::CFG_WIDTH_W;
  localparam int HW   = gbb_pkg::CFG_HEIGHT_W;

  logic [gbb_pkg::CFG_WIDTH_W-1:0] image_width;
  logic [HW-1:0]                   image_height;
  logic [CW-1:0]                   in_col;
  logic [HW-1:0]                   in_row;
  logic [CW-1:0]                   out_col;
  logic [HW-2:0]                   out_row;

  logic [CMPW-1:0] eff_w_ext;
  logic [WW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;
  logic            accept;
  logic            cfg_wr;
  logic [WW-1:0]   in_col_inc;
  logic [WW-1:0]   out_col_inc;
  logic [HW-1:0]   out_row_inc;
  logic            started;
  logic            oc_ge1;
  logic            oc_next_ok;
  logic            or_next_ok;
  logic            last;

  // effective frame size: zero acts as one, oversize clamps
  always_comb begin
    if (image_width == '0) begin
      eff_w_ext = CMPW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      eff_w_ext = CMPW'(MAX_WIDTH);
    end else begin
      eff_w_ext = CMPW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (image_height > gbb_pkg::MAX_HEIGHT) begin
      eff_h = gbb_pkg::MAX_HEIGHT;
    end else begin
      eff_h = image_height;
    end
  end
  assign eff_w = eff_w_ext[WW-1:0];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign q_push    = accept;

  assign in_col_inc  = WW'(in_col) + WW'(1);
  assign out_col_inc = WW'(out_col) + WW'(1);
  assign out_row_inc = {1'b0, out_row} + HW'(1);

  // output due once the arrival index reaches width + 1
  assign started    = (in_row >= HW'(2)) || ((in_row == HW'(1)) && (in_col != '0));
  assign oc_ge1     = (out_col != '0);
  assign oc_next_ok = (out_col_inc < eff_w);
  assign or_next_ok = (out_row_inc < eff_h);
  assign last       = !or_next_ok && !oc_next_ok;

  always_comb begin
    q_col              = in_col;
    q_ctl.have         = started;
    q_ctl.center_right = (in_col == '0);
    q_ctl.last         = last;
    q_ctl.row_ok       = {or_next_ok, 1'b1, (out_row != '0)};
    if (in_col == '0) begin
      // end of previous row: right neighbor lies off the image
      q_ctl.col_ok = {1'b1, oc_ge1, 1'b0};
    end else begin
      q_ctl.col_ok = {oc_next_ok, 1'b1, oc_ge1};
    end
    if ((action == gbb_pkg::ACT_PIXEL) && (in_row < eff_h)) begin
      q_gray = gbb_pkg::luma(red_in, green_in, blue_in);
    end else begin
      q_gray = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gbb_pkg::WIDTH_RESET;
      image_height <= gbb_pkg::HEIGHT_RESET;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == gbb_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data[gbb_pkg::CFG_WIDTH_W-1:0];
        in_col      <= '0;
        in_row      <= '0;
        out_col     <= '0;
        out_row     <= '0;
      end else if (cfg_index == gbb_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
        in_col       <= '0;
        in_row       <= '0;
        out_col      <= '0;
        out_row      <= '0;
      end
    end else if (accept) begin
      if (started && last) begin
        // frame done, next item opens a new image
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_col_inc >= eff_w) begin
          in_col <= '0;
          in_row <= in_row + HW'(1);
        end else begin
          in_col <= in_col_inc[CW-1:0];
        end
        if (started) begin
          if (!oc_next_ok) begin
            out_col <= '0;
            out_row <= out_row_inc[HW-2:0];
          end else begin
            out_col <= out_col_inc[CW-1:0];
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/gbb_back.sv
// gbb_back: line stores, 3x3 window, masked sum, divide by nine and result queue
// depends on gbb_pkg and gbb_fifo; drains the mid queue filled by gbb_front
`timescale 1ns / 1ps

module gbb_back #(
  parameter int MAX_WIDTH = gbb_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // mid queue
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  input  logic [7:0]                   q_gray,
  input  gbb_pkg::gbb_ctl_t            q_ctl,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   gray_blurred,
  output logic                         last_pixel
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int OD   = gbb_pkg::OUT_DEPTH;
  localparam int OCW  = $clog2(OD + 1);
  localparam int SW   = gbb_pkg::SUM_W;

  logic [7:0] upper_mem  [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];

  // stage 1: line store read data and item
  logic              s1_v;
  logic [CW-1:0]     s1_col;
  logic [7:0]        s1_gray;
  gbb_pkg::gbb_ctl_t s1_ctl;
  logic [7:0]        up_q;
  logic [7:0]        mid_q;
  logic              byp;
  logic [7:0]        byp_up;
  logic [7:0]        byp_mid;
  logic [7:0]        s1_up;
  logic [7:0]        s1_mid;

  logic [7:0] win     [3][3];
  logic [7:0] new_col [3];
  logic [7:0] sel     [3][3];
  logic [SW-1:0] sum_next;

  // stage 2: sum waiting for the reciprocal multiply
  logic          s2_v;
  logic [SW-1:0] s2_sum;
  logic          s2_last;

  logic [OCW-1:0] out_count;
  logic [OCW:0]   used;
  logic [8:0]     out_wdata;
  logic [8:0]     out_rdata;

  // only pop when the result queue can hold everything in flight
  assign used  = {1'b0, out_count} + (OCW + 1)'(s1_v) + (OCW + 1)'(s2_v);
  assign q_pop = !q_empty && (used < (OCW + 1)'(OD));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= q_pop;
      s2_v <= s1_v && s1_ctl.have;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_col  <= q_col;
      s1_gray <= q_gray;
      s1_ctl  <= q_ctl;
      // same column as the item writing now (one-pixel rows)
      byp     <= s1_v && (s1_col == q_col);
      byp_up  <= s1_mid;
      byp_mid <= s1_gray;
    end
  end

  // line stores: read at pop, written as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (q_pop) begin
      up_q  <= upper_mem[q_col];
      mid_q <= middle_mem[q_col];
    end
    if (s1_v) begin
      upper_mem[s1_col]  <= s1_mid;
      middle_mem[s1_col] <= s1_gray;
    end
  end

  assign s1_up  = byp ? byp_up : up_q;
  assign s1_mid = byp ? byp_mid : mid_q;

  assign new_col[0] = s1_up;
  assign new_col[1] = s1_mid;
  assign new_col[2] = s1_gray;

  always_ff @(posedge clk) begin
    if (s1_v) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
        win[r][2] <= new_col[r];
      end
    end
  end

  // window before the shift for end-of-row outputs, after it otherwise
  always_comb begin
    sum_next = '0;
    for (int r = 0; r < 3; r++) begin
      if (s1_ctl.center_right) begin
        sel[r][0] = win[r][0];
        sel[r][1] = win[r][1];
        sel[r][2] = win[r][2];
      end else begin
        sel[r][0] = win[r][1];
        sel[r][1] = win[r][2];
        sel[r][2] = new_col[r];
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (s1_ctl.row_ok[r] && s1_ctl.col_ok[c]) begin
          sum_next = sum_next + SW'(sel[r][c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_sum  <= sum_next;
      s2_last <= s1_ctl.last;
    end
  end

  assign out_wdata = {gbb_pkg::div9(s2_sum), s2_last};

  gbb_fifo #(
    .WIDTH (9),
    .DEPTH (OD)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_v),
    .wdata (out_wdata),
    .full  (),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign gray_blurred = out_rdata[8:1];
  assign last_pixel   = out_rdata[0];

endmodule

>>> rtl/core/grayscale_box_blur_3x3_core.sv
// grayscale_box_blur_3x3_core: rgb to luma, then 3x3 mean filter with zero border
// path: the output word that an input word releases passes the mid queue, stage 1
//   and stage 2 into the result queue; the result lags by one image row plus one pixel
// throughput: one input word per cycle unless full is high, set by line stores with one
//   read and one write port each, so a read and a write land in the same cycle
// reset (rst, synchronous): counters, queues clear; size back to 640 x 480
`timescale 1ns / 1ps

module grayscale_box_blur_3x3_core #(
  parameter int MAX_WIDTH = gbb_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            action,
  input  logic [7:0]                      red_in,
  input  logic [7:0]                      green_in,
  input  logic [7:0]                      blue_in,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      gray_blurred,
  output logic                            last_pixel,
  // register writes, to be issued only while the core is idle
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CTLW = $bits(gbb_pkg::gbb_ctl_t);
  localparam int QW   = CW + 8 + CTLW;

  // front to mid queue
  logic              f_push;
  logic              f_full;
  logic [CW-1:0]     f_col;
  logic [7:0]        f_gray;
  gbb_pkg::gbb_ctl_t f_ctl;
  logic [QW-1:0]     f_word;

  // mid queue to back
  logic              b_pop;
  logic              b_empty;
  logic [QW-1:0]     b_word;
  logic [CW-1:0]     b_col;
  logic [7:0]        b_gray;
  gbb_pkg::gbb_ctl_t b_ctl;

  // front: counts raster position, converts to gray, decides which words emit
  gbb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (f_push),
    .q_full    (f_full),
    .q_col     (f_col),
    .q_gray    (f_gray),
    .q_ctl     (f_ctl)
  );

  // classified words: column, gray value, control bits
  assign f_word = {f_col, f_gray, f_ctl};

  // short queue so the front keeps taking words while the back waits on the result side
  gbb_fifo #(
    .WIDTH (QW),
    .DEPTH (gbb_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_word),
    .full  (f_full),
    .pop   (b_pop),
    .rdata (b_word),
    .empty (b_empty),
    .count ()
  );

  assign b_col  = b_word[QW-1 -: CW];
  assign b_gray = b_word[CTLW +: 8];
  assign b_ctl  = gbb_pkg::gbb_ctl_t'(b_word[CTLW-1:0]);

  // back: line stores, window, sum and divide, result queue
  gbb_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (b_empty),
    .q_pop        (b_pop),
    .q_col        (b_col),
    .q_gray       (b_gray),
    .q_ctl        (b_ctl),
    .empty        (empty),
    .pop          (pop),
    .gray_blurred (gray_blurred),
    .last_pixel   (last_pixel)
  );

endmodule
